/* rtl/bgmc_pkg.sv */
package bgmc_pkg;

  typedef enum logic [2:0] {
    ST_CLOSED  = 3'd0,
    ST_OPENING = 3'd1,
    ST_OPEN    = 3'd2,
    ST_CLOSING = 3'd3,
    ST_ERROR   = 3'd4
  } gate_state_e;

  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_OPEN      = 3'd1;
  localparam logic [2:0] MODE_CLOSE     = 3'd2;
  localparam logic [2:0] MODE_RESET_ERR = 3'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd50;
  localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [2:0] mode;
    logic       gate_select;
    logic       open_limit;
    logic       closed_limit;
  } req_t;

  typedef struct packed {
    gate_state_e gate_state;
    logic        motor_on;
    logic        status;
    logic [31:0] move_count;
  } rsp_t;

endpackage

/* rtl/bgmc_gate_bank.sv */
module bgmc_gate_bank #(
  parameter int NUM_GATES = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  input  logic          commit_i,
  input  bgmc_pkg::req_t req_i,
  output bgmc_pkg::rsp_t rsp_o
);

  localparam int GW = (NUM_GATES > 1) ? $clog2(NUM_GATES) : 1;

  logic [15:0] timeout_q;

  bgmc_pkg::gate_state_e state_q [NUM_GATES];
  logic [15:0]           elapsed_q [NUM_GATES];
  logic [31:0]           moves_q [NUM_GATES];
  logic                  motor_q [NUM_GATES];

  logic [GW-1:0]         sel;
  bgmc_pkg::gate_state_e st_cur, st_d;
  logic [15:0]           el_cur, el_d, el_inc;
  logic [31:0]           mv_cur, mv_d;
  logic                  mo_cur, mo_d;
  logic                  status_d;
  logic                  hit;

  always_comb begin
    if (int'(req_i.gate_select) >= NUM_GATES) begin
      sel = GW'(NUM_GATES - 1);
    end else begin
      sel = GW'(req_i.gate_select);
    end
  end

  assign st_cur = state_q[sel];
  assign el_cur = elapsed_q[sel];
  assign mv_cur = moves_q[sel];
  assign mo_cur = motor_q[sel];

  assign el_inc = (el_cur != bgmc_pkg::ELAPSED_MAX) ? el_cur + 16'd1 : el_cur;
  assign hit    = (st_cur == bgmc_pkg::ST_OPENING) ? req_i.open_limit : req_i.closed_limit;

  always_comb begin
    st_d     = st_cur;
    el_d     = el_cur;
    mv_d     = mv_cur;
    mo_d     = mo_cur;
    status_d = 1'b0;
    case (req_i.mode)
      bgmc_pkg::MODE_TICK: begin
        if (st_cur == bgmc_pkg::ST_OPENING || st_cur == bgmc_pkg::ST_CLOSING) begin
          mo_d = 1'b1;
          if (hit) begin
            st_d = (st_cur == bgmc_pkg::ST_OPENING) ? bgmc_pkg::ST_OPEN : bgmc_pkg::ST_CLOSED;
            el_d = '0;
            mv_d = mv_cur + 32'd1;
          end else begin
            el_d = el_inc;
            if (el_inc > timeout_q) begin
              st_d = bgmc_pkg::ST_ERROR;
            end
          end
        end else begin
          mo_d = 1'b0;
        end
      end
      bgmc_pkg::MODE_OPEN: begin
        if (st_cur == bgmc_pkg::ST_ERROR) begin
          status_d = 1'b1;
        end else if (st_cur != bgmc_pkg::ST_OPEN && st_cur != bgmc_pkg::ST_OPENING) begin
          st_d = bgmc_pkg::ST_OPENING;
          el_d = '0;
        end
      end
      bgmc_pkg::MODE_CLOSE: begin
        if (st_cur == bgmc_pkg::ST_ERROR) begin
          status_d = 1'b1;
        end else if (st_cur != bgmc_pkg::ST_CLOSED && st_cur != bgmc_pkg::ST_CLOSING) begin
          st_d = bgmc_pkg::ST_CLOSING;
          el_d = '0;
        end
      end
      bgmc_pkg::MODE_RESET_ERR: begin
        if (st_cur == bgmc_pkg::ST_ERROR) begin
          if (!req_i.closed_limit && req_i.open_limit) begin
            st_d = bgmc_pkg::ST_OPEN;
          end else begin
            st_d = bgmc_pkg::ST_CLOSED;
          end
          el_d = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp_o.gate_state = st_d;
  assign rsp_o.motor_on   = mo_d;
  assign rsp_o.status     = status_d;
  assign rsp_o.move_count = mv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= bgmc_pkg::TIMEOUT_RESET;
      for (int i = 0; i < NUM_GATES; i++) begin
        state_q[i]   <= bgmc_pkg::ST_CLOSED;
        elapsed_q[i] <= '0;
        moves_q[i]   <= '0;
        motor_q[i]   <= 1'b0;
      end
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (commit_i) begin
        state_q[sel]   <= st_d;
        elapsed_q[sel] <= el_d;
        moves_q[sel]   <= mv_d;
        motor_q[sel]   <= mo_d;
      end
    end
  end

endmodule

/* rtl/barrier_gate_motor_controller.sv */
// channel     | dir | tdata                                   | tuser
// s_axis      | in  | [0] open_limit, [1] closed_limit        | [2:0] mode, [3] gate_select
// m_axis      | out | [2:0] gate_state, [3] motor_on,         | [0] status
//             |     | [35:4] move_count                       |
// cfg         | in  | cfg_wdata_i = timeout_ticks             | -
//
// one beat per cycle sustained while m_axis accepts; path: input register, then result register
// the per-gate state update and the result are formed combinationally between them and committed together,
// so back-to-back beats on the same gate see the updated state
// reset clears all gate state, timeout returns to 50 ticks
// when m_axis stalls the result holds; s_axis_tready drops once the input register is full
module barrier_gate_motor_controller #(
  parameter int NUM_GATES = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // open_limit, closed_limit, zero pad
  input  logic [3:0]  s_axis_tuser,   // mode, gate_select
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // gate_state, motor_on, move_count, zero pad
  output logic [0:0]  m_axis_tuser    // status
);

  logic           in_valid_q, in_valid_d;
  bgmc_pkg::req_t in_req_q;
  logic           out_valid_q, out_valid_d;
  bgmc_pkg::rsp_t out_rsp_q;
  bgmc_pkg::rsp_t rsp;
  logic           advance;
  logic           commit;
  logic           in_beat;

  assign advance       = !out_valid_q || m_axis_tready;
  assign commit        = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_beat) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      in_req_q.mode         <= s_axis_tuser[2:0];
      in_req_q.gate_select  <= s_axis_tuser[3];
      in_req_q.open_limit   <= s_axis_tdata[0];
      in_req_q.closed_limit <= s_axis_tdata[1];
    end
    if (commit) begin
      out_rsp_q <= rsp;
    end
  end

  bgmc_gate_bank #(
    .NUM_GATES(NUM_GATES)
  ) u_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .commit_i   (commit),
    .req_i      (in_req_q),
    .rsp_o      (rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'd0, out_rsp_q.move_count, out_rsp_q.motor_on,
                          out_rsp_q.gate_state};
  assign m_axis_tuser  = out_rsp_q.status;

endmodule

/* rtl/bgmc_checker.sv */
module bgmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser
);

  // a refused command only happens in error, and the gate stays there
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[2:0] == bgmc_pkg::ST_ERROR))
    else $error("refused command with gate not in error");

  // an accepted beat leads to m_axis_tvalid being high at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |-> ##2 m_axis_tvalid)
    else $error("accepted beat produced no result");

  // while the result is stalled the input side cannot run ahead more than one beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready && $past(m_axis_tvalid && !m_axis_tready)
     && $past(s_axis_tvalid && s_axis_tready)) |-> !s_axis_tready)
    else $error("input taken while pipeline full");

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed under stall");

endmodule

bind barrier_gate_motor_controller bgmc_checker u_bgmc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
